>>> design/cso_pkg.sv
// ----------------------------------------------------------------------------
// cso_pkg
// Shared types and constants for the cursor sprite overlay blender: payload
// words, register indexes and the arrow sprite art.
// ----------------------------------------------------------------------------
package cso_pkg;

  localparam int SPRITE_WIDTH  = 12;
  localparam int SPRITE_HEIGHT = 18;
  localparam int ART_W         = 12;
  localparam int ART_H         = 18;

  // texels actually drawn: sprite window clipped to the art
  localparam int SPR_W_LIM = (SPRITE_WIDTH  < ART_W) ? SPRITE_WIDTH  : ART_W;
  localparam int SPR_H_LIM = (SPRITE_HEIGHT < ART_H) ? SPRITE_HEIGHT : ART_H;

  localparam int COORD_W = 12;
  localparam int REG_W   = 13;
  localparam int DELTA_W = 14;
  localparam int IDX_W   = 3;

  localparam logic [7:0]  ALPHA_OUTLINE = 8'd220;
  localparam logic [7:0]  ALPHA_BODY    = 8'd235;
  localparam logic [7:0]  ALPHA_OPAQUE  = 8'hFF;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_CURSOR_X     = 3'd0;
  localparam logic [IDX_W-1:0] REG_CURSOR_Y     = 3'd1;
  localparam logic [IDX_W-1:0] REG_CURSOR_VIS   = 3'd2;
  localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 3'd3;
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 3'd4;

  localparam logic [REG_W-1:0] FRAME_WIDTH_RST  = 13'd1920;
  localparam logic [REG_W-1:0] FRAME_HEIGHT_RST = 13'd1080;

  // arrow art, one row per entry, MSB is column 0
  localparam logic [ART_W-1:0] ART_LINE [ART_H] = '{
    12'b1000_0000_0000, 12'b1100_0000_0000, 12'b1010_0000_0000,
    12'b1001_0000_0000, 12'b1000_1000_0000, 12'b1000_0100_0000,
    12'b1000_0010_0000, 12'b1000_0001_0000, 12'b1000_0000_1000,
    12'b1000_0000_0100, 12'b1000_0000_0010, 12'b1000_0100_0010,
    12'b1001_0100_0010, 12'b1010_0100_0010, 12'b1100_0010_0010,
    12'b1000_0001_0010, 12'b0000_0001_0010, 12'b0000_0000_1100
  };

  localparam logic [ART_W-1:0] ART_BODY [ART_H] = '{
    12'b0000_0000_0000, 12'b0000_0000_0000, 12'b0100_0000_0000,
    12'b0110_0000_0000, 12'b0111_0000_0000, 12'b0111_1000_0000,
    12'b0111_1100_0000, 12'b0111_1110_0000, 12'b0111_1111_0000,
    12'b0111_1111_1000, 12'b0111_1111_1100, 12'b0111_1011_1100,
    12'b0110_0011_1100, 12'b0100_0011_1100, 12'b0000_0001_1100,
    12'b0000_0000_1100, 12'b0000_0000_1100, 12'b0000_0000_0000
  };

  typedef struct packed {
    logic [COORD_W-1:0] pix_col;
    logic [COORD_W-1:0] pix_row;
    logic [31:0]        pixel_in;
  } cso_in_t;

  typedef struct packed {
    logic [31:0] pixel_out;
    logic        covered;
  } cso_out_t;

endpackage

>>> design/cursor_sprite_overlay_blend.sv
// ----------------------------------------------------------------------------
// cursor_sprite_overlay_blend
// Hardware cursor overlay: blends a fixed arrow sprite over a BGRA pixel
// stream at a programmable signed position, one pixel per clock.
// ----------------------------------------------------------------------------
// An accepted start passes the input register and then the result register before the out_valid strobe.
// Throughput: one pixel word per cycle; busy is never raised.
// Path: input register, sprite lookup and blend, result register.
// Reset: synchronous rst_n clears the pipeline valids and loads the register
// reset values (cursor at 0,0 hidden, frame 1920x1080).
module cursor_sprite_overlay_blend
  import cso_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  cso_in_t                in_data,
  output logic                   out_valid,
  output cso_out_t               out_data,
  input  logic                   cfg_we,
  input  logic [IDX_W-1:0]       cfg_index,
  input  logic [REG_W-1:0]       cfg_wdata
);

  logic [REG_W-1:0] cur_x_r, cur_y_r, frame_w_r, frame_h_r;
  logic             cur_vis_r;

  logic             vld1_r;
  cso_in_t          in1_r;
  logic             out_valid_r;
  cso_out_t         out_r;
  cso_out_t         out_nxt;

  logic signed [DELTA_W-1:0] dx, dy;
  logic                      in_frame, in_sprite, is_line, is_body;
  logic [3:0]                bit_idx;
  logic [4:0]                row_idx;
  logic [ART_W-1:0]          line_row, body_row;

  function automatic logic [7:0] div255(input logic [13:0] x);
    logic [14:0] t;
    t = 15'(x) + 15'(x >> 8) + 15'd1;
    return t[14:7] >> 1;
  endfunction

  function automatic logic [7:0] blend_line(input logic [7:0] d);
    return div255(14'(d) * 14'd35);
  endfunction

  function automatic logic [7:0] blend_body(input logic [7:0] d);
    return ALPHA_BODY + div255(14'(d) * 14'd20);
  endfunction

  assign busy = 1'b0;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r   <= '0;
      cur_y_r   <= '0;
      cur_vis_r <= 1'b0;
      frame_w_r <= FRAME_WIDTH_RST;
      frame_h_r <= FRAME_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CURSOR_X:     cur_x_r   <= cfg_wdata;
        REG_CURSOR_Y:     cur_y_r   <= cfg_wdata;
        REG_CURSOR_VIS:   cur_vis_r <= cfg_wdata[0];
        REG_FRAME_WIDTH:  frame_w_r <= cfg_wdata;
        REG_FRAME_HEIGHT: frame_h_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else begin
      vld1_r <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start & ~busy) begin
      in1_r <= in_data;
    end
  end

  // sprite hit and blend
  always_comb begin
    dx = $signed({2'b00, in1_r.pix_col}) - $signed({cur_x_r[REG_W-1], cur_x_r});
    dy = $signed({2'b00, in1_r.pix_row}) - $signed({cur_y_r[REG_W-1], cur_y_r});
    in_frame  = cur_vis_r &&
                ({1'b0, in1_r.pix_col} < frame_w_r) &&
                ({1'b0, in1_r.pix_row} < frame_h_r);
    in_sprite = !dx[DELTA_W-1] && !dy[DELTA_W-1] &&
                (dx < DELTA_W'(SPR_W_LIM)) && (dy < DELTA_W'(SPR_H_LIM));
    bit_idx  = 4'(ART_W - 1) - dx[3:0];
    row_idx  = in_sprite ? dy[4:0] : '0;
    line_row = ART_LINE[row_idx];
    body_row = ART_BODY[row_idx];
    is_line  = in_frame && in_sprite && line_row[bit_idx];
    is_body  = in_frame && in_sprite && body_row[bit_idx];

    out_nxt.pixel_out = in1_r.pixel_in;
    out_nxt.covered   = 1'b0;
    if (is_line) begin
      out_nxt.pixel_out = {ALPHA_OPAQUE, blend_line(in1_r.pixel_in[23:16]),
                           blend_line(in1_r.pixel_in[15:8]),
                           blend_line(in1_r.pixel_in[7:0])};
      out_nxt.covered   = 1'b1;
    end else if (is_body) begin
      out_nxt.pixel_out = {ALPHA_OPAQUE, blend_body(in1_r.pixel_in[23:16]),
                           blend_body(in1_r.pixel_in[15:8]),
                           blend_body(in1_r.pixel_in[7:0])};
      out_nxt.covered   = 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (vld1_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_accept_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("accepted word did not produce a result two cycles later");

  a_covered_opaque: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.covered) |-> (out_data.pixel_out[31:24] == ALPHA_OPAQUE))
    else $error("covered pixel without opaque alpha");

  a_pass_through: assert property (@(posedge clk) disable iff (!rst_n)
    (vld1_r && !out_nxt.covered) |=> (out_data.pixel_out == $past(in1_r.pixel_in)))
    else $error("uncovered pixel was modified");

  a_hidden_no_cover: assert property (@(posedge clk) disable iff (!rst_n)
    (vld1_r && !cur_vis_r) |=> !out_data.covered)
    else $error("pixel covered while cursor hidden");
`endif

endmodule
